// File: rtl/spkd_pkg.sv
// Shared types, constants and digit helper for the setpoint keypad display controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package spkd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_SETPOINT   = 3'd0;
  localparam logic [2:0] CFG_MIN_SETPOINT   = 3'd1;
  localparam logic [2:0] CFG_STEP_SIZE      = 3'd2;
  localparam logic [2:0] CFG_CLICK_TICKS    = 3'd3;
  localparam logic [2:0] CFG_BLINK_ON_TICKS = 3'd4;
  localparam logic [2:0] CFG_BLINK_PERIOD   = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT_TICKS  = 3'd6;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 8;

  // Register reset values
  localparam logic [6:0] RST_MAX_SETPOINT   = 7'd75;
  localparam logic [6:0] RST_MIN_SETPOINT   = 7'd35;
  localparam logic [3:0] RST_STEP_SIZE      = 4'd5;
  localparam logic [3:0] RST_CLICK_TICKS    = 4'd3;
  localparam logic [7:0] RST_BLINK_ON_TICKS = 8'd20;
  localparam logic [7:0] RST_BLINK_PERIOD   = 8'd40;
  localparam logic [7:0] RST_TIMEOUT_TICKS  = 8'd100;
  localparam logic [6:0] RST_SETPOINT       = 7'd60;

  localparam logic [6:0] SETPOINT_CEIL = 7'd127;

  typedef enum logic [1:0] {
    DISP_LEAVE = 2'd0,
    DISP_BLANK = 2'd1,
    DISP_SHOW  = 2'd2
  } disp_action_t;

  localparam logic MODE_SHOW_TEMP = 1'b0;
  localparam logic MODE_EDIT      = 1'b1;

  typedef struct packed {
    logic       system_on;
    logic       up_pressed;
    logic       down_pressed;
    logic [6:0] current_temp;
    logic [6:0] stored_setpoint;
  } item_t;

  typedef struct packed {
    disp_action_t display_action;
    logic         digit_position;
    logic [3:0]   digit_value;
    logic         setpoint_write;
    logic [6:0]   setpoint_value;
    logic         setting_mode;
  } result_t;

  typedef struct packed {
    logic [6:0] max_setpoint;
    logic [6:0] min_setpoint;
    logic [3:0] step_size;
    logic [3:0] click_ticks;
    logic [7:0] blink_on_ticks;
    logic [7:0] blink_period;
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [6:0] setpoint;
    logic [3:0] up_count;
    logic [3:0] down_count;
    logic [7:0] blink_count;
    logic [7:0] idle_count;
    logic       digit_toggle;
  } state_t;

  // Tens or units digit of v (v < 128); divide by 10 via reciprocal multiply.
  function automatic logic [3:0] digit_of(input logic [6:0] v, input logic units);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q_x10;
    logic [6:0]  r;
    prod  = {8'd0, v} * 15'd205;
    q     = prod[14:11];
    q_x10 = {q, 3'b000} - {3'b000, q} - {3'b000, q} + {2'b00, q, 1'b0} + {2'b00, q, 1'b0};
    r     = v - q_x10;
    return units ? r[3:0] : q;
  endfunction

endpackage

`default_nettype wire

// File: rtl/spkd_cfg_regs.sv
// Configuration register file of the setpoint keypad display controller.
// Depends on spkd_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module spkd_cfg_regs
  import spkd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [CfgIndexWidth-1:0] wr_index,
  input  wire logic [CfgDataWidth-1:0]  wr_data,
  output cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_setpoint   <= RST_MAX_SETPOINT;
      cfg.min_setpoint   <= RST_MIN_SETPOINT;
      cfg.step_size      <= RST_STEP_SIZE;
      cfg.click_ticks    <= RST_CLICK_TICKS;
      cfg.blink_on_ticks <= RST_BLINK_ON_TICKS;
      cfg.blink_period   <= RST_BLINK_PERIOD;
      cfg.timeout_ticks  <= RST_TIMEOUT_TICKS;
    end else if (wr_en) begin
      // drop writes to indexes past the last register
      unique case (wr_index)
        CFG_MAX_SETPOINT:   cfg.max_setpoint   <= wr_data[6:0];
        CFG_MIN_SETPOINT:   cfg.min_setpoint   <= wr_data[6:0];
        CFG_STEP_SIZE:      cfg.step_size      <= wr_data[3:0];
        CFG_CLICK_TICKS:    cfg.click_ticks    <= wr_data[3:0];
        CFG_BLINK_ON_TICKS: cfg.blink_on_ticks <= wr_data;
        CFG_BLINK_PERIOD:   cfg.blink_period   <= wr_data;
        CFG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/spkd_tick_logic.sv
// Per-tick next-state and result logic: button clicks, mode, blink and setpoint edit.
// Purely combinational; depends on spkd_pkg.
`default_nettype none

module spkd_tick_logic
  import spkd_pkg::*;
(
  input  wire cfg_t   cfg,
  input  wire state_t state,
  input  wire item_t  item,
  output state_t      state_next,
  output result_t     result
);

  logic [3:0] up_inc;
  logic [3:0] down_inc;
  logic       click_up;
  logic       click_down;
  logic [7:0] blink_inc;
  logic [7:0] idle_inc;
  logic [7:0] up_sum;
  logic [6:0] sp_raised;
  logic [6:0] sp_lowered;

  always_comb begin
    up_inc    = item.up_pressed ? state.up_count + 4'd1 : 4'd0;
    down_inc  = (!item.up_pressed && item.down_pressed) ? state.down_count + 4'd1 : 4'd0;
    click_up  = (up_inc == cfg.click_ticks);
    click_down = !click_up && (down_inc == cfg.click_ticks);
    blink_inc = state.blink_count + 8'd1;
    idle_inc  = state.idle_count + 8'd1;
    up_sum    = {1'b0, state.setpoint} + {4'd0, cfg.step_size};
    sp_raised = up_sum[7] ? SETPOINT_CEIL : up_sum[6:0];
    sp_lowered = (state.setpoint > {3'd0, cfg.step_size})
               ? state.setpoint - {3'd0, cfg.step_size} : 7'd0;
  end

  always_comb begin
    state_next = state;
    result.display_action = DISP_LEAVE;
    result.digit_position = 1'b0;
    result.digit_value    = 4'd0;
    result.setpoint_write = 1'b0;

    if (!item.system_on) begin
      // hold all state, blank the display
      result.display_action = DISP_BLANK;
    end else begin
      state_next.up_count   = click_up ? 4'd0 : up_inc;
      state_next.down_count = click_down ? 4'd0 : down_inc;

      if (state.mode == MODE_SHOW_TEMP) begin
        result.display_action   = DISP_SHOW;
        result.digit_position   = state.digit_toggle;
        result.digit_value      = digit_of(item.current_temp, state.digit_toggle);
        state_next.digit_toggle = !state.digit_toggle;
        if (click_up || click_down) begin
          state_next.mode        = MODE_EDIT;
          state_next.setpoint    = item.stored_setpoint;
          state_next.blink_count = 8'd0;
        end
      end else begin
        state_next.blink_count = blink_inc;
        priority if (blink_inc < cfg.blink_on_ticks) begin
          result.display_action   = DISP_SHOW;
          result.digit_position   = state.digit_toggle;
          result.digit_value      = digit_of(state.setpoint, state.digit_toggle);
          state_next.digit_toggle = !state.digit_toggle;
        end else if (blink_inc < cfg.blink_period) begin
          result.display_action = DISP_BLANK;
        end else begin
          state_next.blink_count = 8'd0;
        end

        priority if (click_up) begin
          if (state.setpoint < cfg.max_setpoint) state_next.setpoint = sp_raised;
          state_next.idle_count = 8'd0;
        end else if (click_down) begin
          if (state.setpoint > cfg.min_setpoint) state_next.setpoint = sp_lowered;
          state_next.idle_count = 8'd0;
        end else if (idle_inc == cfg.timeout_ticks) begin
          // timeout: save and return to normal
          state_next.mode       = MODE_SHOW_TEMP;
          state_next.idle_count = 8'd0;
          result.setpoint_write = 1'b1;
        end else begin
          state_next.idle_count = idle_inc;
        end
      end
    end

    result.setpoint_value = state_next.setpoint;
    result.setting_mode   = state_next.mode;
  end

endmodule

`default_nettype wire

// File: rtl/setpoint_keypad_display_controller_core.sv
// Setpoint keypad display controller: input register, tick logic, result register.
// Items pass the input register, then the result register. Throughput: one item per cycle
// while not stalled; the single tick logic stage sets that figure.
// Reset (rst, synchronous): state and registers return to their reset values,
// both pipeline stages empty. Depends on spkd_pkg, spkd_cfg_regs, spkd_tick_logic.
`default_nettype none

module setpoint_keypad_display_controller_core
  import spkd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire item_t                    item,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output result_t                       result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   stage_item;
  logic    stage_valid;
  result_t result_next;
  logic    advance;

  assign cfg_ready = 1'b1;

  spkd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  spkd_tick_logic u_tick (
    .cfg        (cfg),
    .state      (state),
    .item       (stage_item),
    .state_next (state_next),
    .result     (result_next)
  );

  // advance the pipeline when the result register is empty or being taken
  assign advance    = !result_valid || !result_stall;
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) stage_item <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid       <= 1'b0;
      state.mode         <= MODE_SHOW_TEMP;
      state.setpoint     <= RST_SETPOINT;
      state.up_count     <= 4'd0;
      state.down_count   <= 4'd0;
      state.blink_count  <= 8'd0;
      state.idle_count   <= 8'd0;
      state.digit_toggle <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
      if (stage_valid) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) result <= result_next;
  end

endmodule

`default_nettype wire

// File: rtl/spkd_checker.sv
// Port-level checks for setpoint_keypad_display_controller_core, attached by bind.
// Depends on spkd_pkg for the result type and display action codes.
`default_nettype none

module spkd_checker
  import spkd_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // stalled result transaction holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a save always returns to normal mode
  a_write_normal: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.setpoint_write |-> result.setting_mode == MODE_SHOW_TEMP)
    else $error("setpoint saved while staying in setting mode");

  // digit fields are zero unless a digit is shown
  a_digit_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.display_action != DISP_SHOW |->
      result.digit_position == 1'b0 && result.digit_value == 4'd0)
    else $error("digit fields set without a digit shown");

endmodule

bind setpoint_keypad_display_controller_core spkd_checker u_spkd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
